@@ sv/pmb_pkg.sv @@
// Shared types and constants of the ping-pong mailbox.
// Used by the front queue, the engine and the top level; depends on nothing.
package pmb_pkg;

    localparam int SLOTS       = 8;
    localparam int WORD_BITS   = 64;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int STORE_DEPTH = 2 * (1 << IDX_W);
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 264;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ELEM  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_ACK   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NO_DATA   = 3'd1,
        STS_BOTH_BUSY = 3'd2,
        STS_BAD_LEN   = 3'd3,
        STS_ELEM_IGN  = 3'd4,
        STS_ACK_DONE  = 3'd5
    } t_status;

    typedef enum logic {
        S_RUN  = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  frame_length;
        logic [63:0] element_data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        t_status     status;
        logic [63:0] read_data;
        logic        last;
        logic        send_ack;
        logic        slot;
        logic [31:0] sequence_res;
        logic [31:0] seq_error_total;
        logic [31:0] switch_total;
        logic [31:0] busy_total;
        logic [31:0] write_total;
        logic [31:0] read_total;
    } t_result;

endpackage

@@ sv/pmb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/pmb_front.sv @@
// Front queue: accepts items, decodes the command and holds up to two items.
// Depends on pmb_pkg.
module pmb_front
    import pmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_frame_length,
    input  logic [63:0] i_element_data,
    output t_q_head     o_head,
    input  logic        i_pop
);

    t_item      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_item      item_in;

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready;

    always_comb begin
        item_in.cmd          = t_cmd'(i_command);
        item_in.frame_length = i_frame_length;
        item_in.element_data = i_element_data;
    end

    always_comb begin
        n_wptr  = r_wptr ^ push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item_in;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

endmodule

@@ sv/pmb_engine.sv @@
// Mailbox engine: slot flags, sequences, counters, the slot store and the
// result register. Depends on pmb_pkg and pmb_ram.
module pmb_engine
    import pmb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_state           r_state, n_state;
    logic             r_full [2];
    logic             n_full [2];
    logic [31:0]      r_seq [2];
    logic [31:0]      n_seq [2];
    logic             r_wslot, n_wslot;
    logic             r_rslot, n_rslot;
    logic [31:0]      r_prev_seq, n_prev_seq;
    logic [CNT_W-1:0] r_fill_pos, n_fill_pos;
    logic [CNT_W-1:0] r_fill_tgt, n_fill_tgt;
    logic             r_open, n_open;
    logic [31:0]      r_seqerr, n_seqerr;
    logic [31:0]      r_switch, n_switch;
    logic [31:0]      r_busy, n_busy;
    logic [31:0]      r_write, n_write;
    logic [31:0]      r_read, n_read;
    logic             r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0] r_fetch, n_fetch;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    logic             r_pend_vld, n_pend_vld;
    logic [STORE_DEPTH-1:0] r_vld, n_vld;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic                 out_free;
    logic                 emit;
    t_status              sts;
    logic                 res_slot;
    logic                 ws;
    logic                 rs;
    logic                 load;
    logic                 issue;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [CNT_W-1:0]     fill_next;

    assign out_free  = !r_out_valid || i_ready;
    assign ram_raddr = {r_rd_slot, r_fetch[IDX_W-1:0]};
    assign ram_waddr = {r_wslot, r_fill_pos[IDX_W-1:0]};
    assign fill_next = r_fill_pos + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_full      = r_full;
        n_seq       = r_seq;
        n_wslot     = r_wslot;
        n_rslot     = r_rslot;
        n_prev_seq  = r_prev_seq;
        n_fill_pos  = r_fill_pos;
        n_fill_tgt  = r_fill_tgt;
        n_open      = r_open;
        n_seqerr    = r_seqerr;
        n_switch    = r_switch;
        n_busy      = r_busy;
        n_write     = r_write;
        n_read      = r_read;
        n_rd_slot   = r_rd_slot;
        n_fetch     = r_fetch;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_pend_vld  = r_pend_vld;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        emit        = 1'b0;
        sts         = STS_OK;
        ws          = r_wslot;
        rs          = r_rslot;
        res_slot    = r_wslot;
        load        = 1'b0;
        issue       = 1'b0;
        ram_we      = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (i_head.item.cmd)
                        CMD_BEGIN: begin
                            n_open = 1'b0;
                            if (i_head.item.frame_length > 8'(SLOTS)) begin
                                sts = STS_BAD_LEN;
                            end else if (r_full[ws] && r_full[~ws]) begin
                                sts    = STS_BOTH_BUSY;
                                n_busy = r_busy + 32'd1;
                            end else begin
                                if (r_full[ws]) begin
                                    ws       = ~ws;
                                    n_wslot  = ws;
                                    n_switch = r_switch + 32'd1;
                                end
                                n_fill_pos = '0;
                                n_fill_tgt = CNT_W'(i_head.item.frame_length);
                                n_open     = 1'b1;
                                // zero-length frame commits right away
                                if (i_head.item.frame_length == 8'd0) begin
                                    n_seq[ws]  = r_seq[ws] + 32'd1;
                                    n_full[ws] = 1'b1;
                                    n_write    = r_write + 32'd1;
                                    n_open     = 1'b0;
                                end
                            end
                            res_slot = ws;
                        end
                        CMD_ELEM: begin
                            if (!r_open || r_fill_pos >= CNT_W'(SLOTS)) begin
                                sts = STS_ELEM_IGN;
                            end else begin
                                ram_we            = 1'b1;
                                n_vld[ram_waddr]  = 1'b1;
                                n_fill_pos        = fill_next;
                                if (fill_next >= r_fill_tgt) begin
                                    n_seq[ws]  = r_seq[ws] + 32'd1;
                                    n_full[ws] = 1'b1;
                                    n_write    = r_write + 32'd1;
                                    n_open     = 1'b0;
                                end
                            end
                        end
                        CMD_READ: begin
                            res_slot = rs;
                            if (!r_full[rs]) begin
                                sts = STS_NO_DATA;
                            end else begin
                                emit = 1'b0;
                                if (r_prev_seq != 32'd0 &&
                                    r_seq[rs] != r_prev_seq + 32'd1) begin
                                    n_seqerr = r_seqerr + 32'd1;
                                end
                                n_prev_seq = r_seq[rs];
                                n_full[rs] = 1'b0;
                                n_read     = r_read + 32'd1;
                                n_rslot    = ~rs;
                                n_rd_slot  = rs;
                                n_fetch    = '0;
                                n_pend     = 1'b0;
                                n_state    = S_READ;
                            end
                        end
                        CMD_ACK: begin
                            sts        = STS_ACK_DONE;
                            n_full[ws] = 1'b0;
                        end
                        default: begin
                            sts = STS_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                // one RAM read in flight; hold it in the RAM register while stalled
                load  = r_pend && out_free;
                issue = (r_fetch != CNT_W'(SLOTS)) && (!r_pend || load);
                if (issue) begin
                    n_fetch     = r_fetch + CNT_W'(1);
                    n_pend_last = (r_fetch == CNT_W'(SLOTS - 1));
                    n_pend_vld  = r_vld[ram_raddr];
                end
                n_pend = issue || (r_pend && !load);
                if (load) begin
                    n_out_valid            = 1'b1;
                    n_out.status           = STS_OK;
                    n_out.read_data        = r_pend_vld ? 64'(ram_rdata) : 64'd0;
                    n_out.last             = r_pend_last;
                    n_out.send_ack         = r_pend_last;
                    n_out.slot             = r_rd_slot;
                    n_out.sequence_res     = r_seq[r_rd_slot];
                    n_out.seq_error_total  = r_seqerr;
                    n_out.switch_total     = r_switch;
                    n_out.busy_total       = r_busy;
                    n_out.write_total      = r_write;
                    n_out.read_total       = r_read;
                    if (r_pend_last) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (emit) begin
            n_out_valid           = 1'b1;
            n_out.status          = sts;
            n_out.read_data       = 64'd0;
            n_out.last            = 1'b1;
            n_out.send_ack        = 1'b0;
            n_out.slot            = res_slot;
            n_out.sequence_res    = n_seq[res_slot];
            n_out.seq_error_total = n_seqerr;
            n_out.switch_total    = n_switch;
            n_out.busy_total      = n_busy;
            n_out.write_total     = n_write;
            n_out.read_total      = n_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_full      <= '{1'b0, 1'b0};
            r_seq       <= '{32'd0, 32'd0};
            r_wslot     <= 1'b0;
            r_rslot     <= 1'b0;
            r_prev_seq  <= 32'd0;
            r_fill_pos  <= '0;
            r_fill_tgt  <= '0;
            r_open      <= 1'b0;
            r_seqerr    <= 32'd0;
            r_switch    <= 32'd0;
            r_busy      <= 32'd0;
            r_write     <= 32'd0;
            r_read      <= 32'd0;
            r_rd_slot   <= 1'b0;
            r_fetch     <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_seq       <= n_seq;
            r_wslot     <= n_wslot;
            r_rslot     <= n_rslot;
            r_prev_seq  <= n_prev_seq;
            r_fill_pos  <= n_fill_pos;
            r_fill_tgt  <= n_fill_tgt;
            r_open      <= n_open;
            r_seqerr    <= n_seqerr;
            r_switch    <= n_switch;
            r_busy      <= n_busy;
            r_write     <= n_write;
            r_read      <= n_read;
            r_rd_slot   <= n_rd_slot;
            r_fetch     <= n_fetch;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_pend_vld  <= n_pend_vld;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    pmb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_head.item.element_data[WORD_BITS-1:0]),
        .i_re    (issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ sv/ping_pong_mailbox.sv @@
// Top level of the two-slot ping-pong mailbox: stream ports and packing.
// Depends on pmb_pkg, pmb_front and pmb_engine.
//
// Two-slot ping-pong mailbox. Items enter a two-deep queue and are carried
// out in order by the engine. Begin, write-element, acknowledge and a read
// of an empty slot each give one result. A read of a full slot gives SLOTS
// results, the last with tlast and send_ack set. Its first word goes from
// the issue of the slot store read through the store's registered read data
// to the result register. The rest follow one per cycle while the output is
// not stalled, and the engine takes no new item until the last word is
// loaded; the slot store has a single read port. Output stalls hold the
// engine; the queue keeps taking items until it holds two.
// The store reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed.
module ping_pong_mailbox
    import pmb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] frame_length, [71:8] element_data
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [63:0] read_data, [64] send_ack, [65] slot, [97:66] sequence_res,
    // [129:98] seq_error_total, [161:130] switch_total, [193:162] busy_total,
    // [225:194] write_total, [257:226] read_total, [263:258] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    t_q_head head;
    logic    pop;
    t_result res;

    pmb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_command      (i_s_axis_tuser),
        .i_frame_length (i_s_axis_tdata[7:0]),
        .i_element_data (i_s_axis_tdata[71:8]),
        .o_head         (head),
        .i_pop          (pop)
    );

    pmb_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    assign o_m_axis_tdata = {6'd0, res.read_total, res.write_total, res.busy_total,
                             res.switch_total, res.seq_error_total, res.sequence_res,
                             res.slot, res.send_ack, res.read_data};
    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tlast = res.last;

endmodule

@@ tb/ping_pong_mailbox_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ping-pong mailbox: mirrors the slot state, predicts the
// results of every accepted item and compares them with the output stream.
// Depends on pmb_pkg.
module ping_pong_mailbox_checker
    import pmb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_valid,
    input  logic                   i_s_ready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]             i_s_tuser,
    input  logic                   i_m_valid,
    input  logic                   i_m_ready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [2:0]             i_m_tuser,
    input  logic                   i_m_tlast,
    output int                     o_failures,
    output int                     o_due
);

    // mirror of the mailbox state
    logic [WORD_BITS-1:0] slot_words [2*SLOTS];
    logic [1:0]           slot_full;
    logic [31:0]          slot_seq [2];
    logic                 wr_slot;
    logic                 rd_slot;
    logic [31:0]          last_read_seq;
    logic [7:0]           fill_pos;
    logic [7:0]           fill_len;
    logic                 frame_open;
    logic [31:0]          n_seq_err;
    logic [31:0]          n_switch;
    logic [31:0]          n_busy;
    logic [31:0]          n_write;
    logic [31:0]          n_read;

    t_result due_results[$];
    int      failures = 0;

    task automatic push_result(input t_status st, input logic [63:0] data,
                               input logic fin, input logic ack, input logic s);
        t_result r;
        r.status          = st;
        r.read_data       = data;
        r.last            = fin;
        r.send_ack        = ack;
        r.slot            = s;
        r.sequence_res    = slot_seq[s];
        r.seq_error_total = n_seq_err;
        r.switch_total    = n_switch;
        r.busy_total      = n_busy;
        r.write_total     = n_write;
        r.read_total      = n_read;
        due_results.push_back(r);
    endtask

    task automatic commit_frame();
        slot_seq[wr_slot]  = slot_seq[wr_slot] + 32'd1;
        slot_full[wr_slot] = 1'b1;
        n_write            = n_write + 32'd1;
        frame_open         = 1'b0;
    endtask

    // Advance the mirrored state by one item and queue what it should produce.
    task automatic mailbox_apply(input t_cmd cmd, input logic [7:0] len,
                                 input logic [63:0] data);
        logic        ws;
        logic        rs;
        logic [31:0] rseq;
        ws = wr_slot;
        rs = rd_slot;
        case (cmd)
            CMD_BEGIN: begin
                // an open frame is dropped whatever happens next
                frame_open = 1'b0;
                if (len > SLOTS) begin
                    push_result(STS_BAD_LEN, '0, 1'b1, 1'b0, ws);
                end else if (slot_full[ws] && slot_full[!ws]) begin
                    n_busy = n_busy + 32'd1;
                    push_result(STS_BOTH_BUSY, '0, 1'b1, 1'b0, ws);
                end else begin
                    if (slot_full[ws]) begin
                        ws       = !ws;
                        wr_slot  = ws;
                        n_switch = n_switch + 32'd1;
                    end
                    fill_pos   = '0;
                    fill_len   = len;
                    frame_open = 1'b1;
                    if (len == 0) commit_frame();
                    push_result(STS_OK, '0, 1'b1, 1'b0, ws);
                end
            end
            CMD_ELEM: begin
                if (!frame_open || fill_pos >= SLOTS) begin
                    push_result(STS_ELEM_IGN, '0, 1'b1, 1'b0, ws);
                end else begin
                    slot_words[ws * SLOTS + fill_pos] = data[WORD_BITS-1:0];
                    fill_pos = fill_pos + 8'd1;
                    if (fill_pos >= fill_len) commit_frame();
                    push_result(STS_OK, '0, 1'b1, 1'b0, ws);
                end
            end
            CMD_READ: begin
                if (!slot_full[rs]) begin
                    push_result(STS_NO_DATA, '0, 1'b1, 1'b0, rs);
                end else begin
                    rseq = slot_seq[rs];
                    if (last_read_seq != 0 && rseq != last_read_seq + 32'd1)
                        n_seq_err = n_seq_err + 32'd1;
                    last_read_seq = rseq;
                    slot_full[rs] = 1'b0;
                    n_read        = n_read + 32'd1;
                    rd_slot       = !rs;
                    for (int i = 0; i < SLOTS; i++)
                        push_result(STS_OK, 64'(slot_words[rs * SLOTS + i]),
                                    i == SLOTS - 1, i == SLOTS - 1, rs);
                end
            end
            default: begin
                slot_full[ws] = 1'b0;
                push_result(STS_ACK_DONE, '0, 1'b1, 1'b0, ws);
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (slot_words[i]) slot_words[i] = '0;
            slot_full     = '0;
            slot_seq[0]   = '0;
            slot_seq[1]   = '0;
            wr_slot       = 1'b0;
            rd_slot       = 1'b0;
            last_read_seq = '0;
            fill_pos      = '0;
            fill_len      = '0;
            frame_open    = 1'b0;
            n_seq_err     = '0;
            n_switch      = '0;
            n_busy        = '0;
            n_write       = '0;
            n_read        = '0;
            due_results.delete();
        end else begin
            // compare outputs before taking this edge's item, so a result
            // can never be matched against an item accepted at the same edge
            if (i_m_valid && i_m_ready) begin
                got.status          = t_status'(i_m_tuser);
                got.read_data       = i_m_tdata[63:0];
                got.last            = i_m_tlast;
                got.send_ack        = i_m_tdata[64];
                got.slot            = i_m_tdata[65];
                got.sequence_res    = i_m_tdata[97:66];
                got.seq_error_total = i_m_tdata[129:98];
                got.switch_total    = i_m_tdata[161:130];
                got.busy_total      = i_m_tdata[193:162];
                got.write_total     = i_m_tdata[225:194];
                got.read_total      = i_m_tdata[257:226];
                if (due_results.size() == 0) begin
                    $error("result with status %0d arrived with nothing expected",
                           i_m_tuser);
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("last", want.last, got.last);
                    check_field("send_ack", want.send_ack, got.send_ack);
                    check_field("slot", want.slot, got.slot);
                    check_field("sequence_res", want.sequence_res, got.sequence_res);
                    check_field("seq_error_total", want.seq_error_total,
                                got.seq_error_total);
                    check_field("switch_total", want.switch_total, got.switch_total);
                    check_field("busy_total", want.busy_total, got.busy_total);
                    check_field("write_total", want.write_total, got.write_total);
                    check_field("read_total", want.read_total, got.read_total);
                end
            end
            if (i_s_valid && i_s_ready)
                mailbox_apply(t_cmd'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[71:8]);
        end
        o_due      <= due_results.size();
        o_failures <= failures;
    end

endmodule

@@ tb/tb_ping_pong_mailbox.sv @@
`timescale 1ns / 1ps
// Testbench top for the ping-pong mailbox: clock, reset, item stimulus and
// output back-pressure. Depends on pmb_pkg, ping_pong_mailbox and the checker.
module tb_ping_pong_mailbox;
    import pmb_pkg::*;

    localparam int TOTAL_ITEMS  = 310;
    localparam int HOLD_CYCLES  = 80;
    localparam int LIMIT_CYCLES = 200000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   src_valid = 1'b0;
    logic                   src_ready;
    logic [IN_TDATA_W-1:0]  src_tdata = '0;
    logic [1:0]             src_tuser = '0;
    logic                   snk_valid;
    logic                   snk_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] snk_tdata;
    logic [2:0]             snk_tuser;
    logic                   snk_tlast;
    int                     failures;
    int                     due;

    logic        quiet   = 1'b0;
    logic        hold_go = 1'b0;
    int          n_sent  = 0;
    int unsigned cycles  = 0;

    always #1 clk = ~clk;

    ping_pong_mailbox i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_tdata),
        .i_s_axis_tuser  (src_tuser),
        .o_m_axis_tvalid (snk_valid),
        .i_m_axis_tready (snk_ready),
        .o_m_axis_tdata  (snk_tdata),
        .o_m_axis_tuser  (snk_tuser),
        .o_m_axis_tlast  (snk_tlast)
    );

    ping_pong_mailbox_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_valid  (src_valid),
        .i_s_ready  (src_ready),
        .i_s_tdata  (src_tdata),
        .i_s_tuser  (src_tuser),
        .i_m_valid  (snk_valid),
        .i_m_ready  (snk_ready),
        .i_m_tdata  (snk_tdata),
        .i_m_tuser  (snk_tuser),
        .i_m_tlast  (snk_tlast),
        .o_failures (failures),
        .o_due      (due)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one item, with random idle cycles ahead of it; return at the
    // edge where it is taken.
    task automatic send_item(input t_cmd cmd, input logic [7:0] len,
                             input logic [63:0] data);
        while (!quiet && $urandom_range(99) < 9) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_tuser <= cmd;
        src_tdata <= {data, len};
        @(posedge clk);
        while (!src_ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (due != 0) @(posedge clk);
    endtask

    // output side: random stalls, one long hold-off, no stalls while quiet
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                snk_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            snk_ready <= quiet || $urandom_range(99) >= 9;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("ping_pong_mailbox verification failed");
            $finish;
        end
    end

    initial begin
        int          pick;
        int          cut;
        logic [7:0]  len;
        bit          held   = 1'b0;
        bit          paused = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty mailbox: nothing to read, ack on nothing, stray element
        send_item(CMD_READ, 8'h00, 64'h0);
        send_item(CMD_ACK, 8'hff, 64'h0);
        send_item(CMD_ELEM, 8'h00, '1);
        // lengths above the slot count
        send_item(CMD_BEGIN, 8'hff, 64'h0);
        send_item(CMD_BEGIN, 8'(SLOTS + 1), 64'h0);
        // empty frame commits on begin, then a full frame switches slots
        send_item(CMD_BEGIN, 8'h00, 64'h0);
        send_item(CMD_BEGIN, 8'(SLOTS), 64'h0);
        send_item(CMD_ELEM, 8'h00, '1);
        send_item(CMD_ELEM, 8'h00, 64'h0);
        send_item(CMD_ELEM, 8'h00, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(CMD_ELEM, 8'h00, 64'h5555_5555_5555_5555);
        for (int i = 0; i < SLOTS - 4; i++)
            send_item(CMD_ELEM, 8'h00, rand_word());
        // both slots full: reject, and stray element after commit
        send_item(CMD_BEGIN, 8'h03, 64'h0);
        send_item(CMD_ELEM, 8'h00, 64'h1);
        // drain both slots, then one read too many
        send_item(CMD_READ, 8'h00, 64'h0);
        send_item(CMD_READ, 8'h00, 64'h0);
        send_item(CMD_READ, 8'h00, 64'h0);
        // begin over an open frame drops it; ack clears the committed slot
        send_item(CMD_BEGIN, 8'h02, 64'h0);
        send_item(CMD_ELEM, 8'h00, rand_word());
        send_item(CMD_BEGIN, 8'h01, 64'h0);
        send_item(CMD_ELEM, 8'h00, rand_word());
        send_item(CMD_ACK, 8'h00, 64'h0);

        while (n_sent < TOTAL_ITEMS) begin
            if (!held && n_sent >= 70) begin
                held = 1'b1;
                hold_go <= 1'b1;
            end
            if (!paused && n_sent >= 150) begin
                paused = 1'b1;
                wait_drained();
            end
            quiet <= n_sent >= 180 && n_sent < 260;
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = ($urandom_range(3) == 0) ? 8'(SLOTS) : 8'($urandom_range(SLOTS));
                send_item(CMD_BEGIN, len, rand_word());
                // cut some frames short so the next begin abandons them
                cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
                for (int j = 0; j < cut; j++)
                    send_item(CMD_ELEM, 8'($urandom_range(255)), rand_word());
            end else if (pick < 75) begin
                send_item(CMD_READ, 8'($urandom_range(255)), rand_word());
            end else if (pick < 85) begin
                send_item(CMD_ACK, 8'($urandom_range(255)), rand_word());
            end else begin
                send_item(t_cmd'($urandom_range(3)), 8'($urandom_range(255)),
                          rand_word());
            end
        end

        quiet <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (failures == 0) begin
            $display("ping_pong_mailbox verification clean");
        end else begin
            $display("ping_pong_mailbox verification failed");
        end
        $finish;
    end

endmodule
